@@ sv/emg_pkg.sv @@
package emg_pkg;

	// Field and register widths
	localparam int SAMPLE_W  = 15;
	localparam int TIME_W    = 32;
	localparam int DEV_W     = 12;
	localparam int LOCK_W    = 16;
	localparam int DIR_W     = 2;
	localparam int EVENT_W   = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_DEVIATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE1     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE2     = 2'd3;

	// Reset values
	localparam logic [DEV_W-1:0]    DEVIATION_RST = 12'd25;
	localparam logic [LOCK_W-1:0]   LOCKOUT_RST   = 16'd2000;
	localparam logic [SAMPLE_W-1:0] BASE_RST      = 15'd1030;

	// Direction codes
	localparam logic [DIR_W-1:0] DIR_NEG  = 2'd0;
	localparam logic [DIR_W-1:0] DIR_POS  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_IDLE = 2'd2;

	// Gripper event codes
	localparam logic [EVENT_W-1:0] EV_NONE  = 2'd0;
	localparam logic [EVENT_W-1:0] EV_OPEN  = 2'd1;
	localparam logic [EVENT_W-1:0] EV_CLOSE = 2'd2;

	// ceil(2^20 / 5): exact floor division by five for any value below 2^18
	localparam int               BLEND_W     = 18;
	localparam int               RECIP_SHIFT = 20;
	localparam logic [BLEND_W-1:0] RECIP_FIVE = 18'd209716;

	// floor((2*s + 3*b) / 5) by reciprocal multiply
	function automatic logic [SAMPLE_W-1:0] blend(input logic [SAMPLE_W-1:0] s,
			input logic [SAMPLE_W-1:0] b);
		logic [BLEND_W-1:0]   sum;
		logic [2*BLEND_W-1:0] prod;
		sum  = {2'b00, s, 1'b0} + {2'b00, b, 1'b0} + {3'b000, b};
		prod = {{BLEND_W{1'b0}}, sum} * {{BLEND_W{1'b0}}, RECIP_FIVE};
		return prod[RECIP_SHIFT+SAMPLE_W-1:RECIP_SHIFT];
	endfunction

endpackage

@@ sv/emg_if.sv @@
interface emg_sample_if import emg_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample_one;
	logic [SAMPLE_W-1:0] sample_two;
	logic [TIME_W-1:0]   now_ms;

	modport source (output valid, output sample_one, output sample_two, output now_ms,
		input ready);
	modport sink (input valid, input sample_one, input sample_two, input now_ms,
		output ready);
endinterface

interface emg_result_if import emg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [DIR_W-1:0]   direction;
	logic [EVENT_W-1:0] grip_event;

	modport source (output valid, output direction, output grip_event, input ready);
	modport sink (input valid, input direction, input grip_event, output ready);
endinterface

@@ sv/emg_gesture_classifier.sv @@
// Channel   | Role   | Payload                                | Transfer
// samples   | sink   | sample_one[15], sample_two[15], now_ms | valid && ready
// results   | source | direction[2], grip_event[2]            | valid && ready
// cfg       | write  | cfg_index[2], cfg_data[16]             | cfg_we
//
// One sample pair a cycle unless results.ready stalls the result register; each item is
// registered in stage 1 and then in the stage 2 result register before its result transfer.
// Stage 1 holds the input item; the decision, the divide-by-five baseline blend and
// the lockout check run between it and the result register, and the state
// (baselines, direction, gripper, last toggle time) updates as the item advances.
// arst_n clears valids, direction (idle), gripper (closed) and the timestamp; the
// baselines and thresholds reload their defaults. A stalled result register holds
// stage 1, and ready drops only when both are full and results.ready is low.
module emg_gesture_classifier import emg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	emg_sample_if.sink           samples,
	emg_result_if.source         results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	// Configuration
	logic [DEV_W-1:0]  deviation_q;
	logic [LOCK_W-1:0] lockout_q;

	// Block state
	logic [SAMPLE_W-1:0] base_one_q;
	logic [SAMPLE_W-1:0] base_two_q;
	logic [DIR_W-1:0]    dir_q;
	logic                grip_open_q;
	logic [TIME_W-1:0]   last_toggle_q;

	// Stage 1: input register
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_one_s1;
	logic [SAMPLE_W-1:0] sample_two_s1;
	logic [TIME_W-1:0]   now_ms_s1;

	// Stage 2: result register
	logic               valid_s2;
	logic [DIR_W-1:0]   direction_s2;
	logic [EVENT_W-1:0] grip_event_s2;

	// Decision logic
	logic                advance;
	logic [SAMPLE_W:0]   thr_one;
	logic [SAMPLE_W:0]   thr_two;
	logic [SAMPLE_W+1:0] thr_neg;
	logic                ch1_strong;
	logic                ch2_active;
	logic                ch2_neg;
	logic [TIME_W-1:0]   elapsed;
	logic                toggle;
	logic                upd_one;
	logic                upd_two;
	logic [DIR_W-1:0]    dir_nxt;
	logic [EVENT_W-1:0]  event_nxt;
	logic [SAMPLE_W-1:0] blend_one;
	logic [SAMPLE_W-1:0] blend_two;

	// Advance stage 1 when the result register is empty or being drained
	assign advance       = valid_s1 && (!valid_s2 || results.ready);
	assign samples.ready = !valid_s1 || advance;

	assign thr_one    = {1'b0, base_one_q} + {3'b000, deviation_q, 1'b0};
	assign thr_two    = {1'b0, base_two_q} + {4'b0000, deviation_q};
	assign thr_neg    = {1'b0, base_two_q, 1'b0} + {5'b00000, deviation_q};
	assign ch1_strong = {1'b0, sample_one_s1} > thr_one;
	assign ch2_active = {1'b0, sample_two_s1} > thr_two;
	// Half-deviation test on doubled values
	assign ch2_neg    = {1'b0, sample_two_s1, 1'b0} > thr_neg;

	// Elapsed time wraps with the timestamp
	assign elapsed = now_ms_s1 - last_toggle_q;

	assign blend_one = blend(sample_one_s1, base_one_q);
	assign blend_two = blend(sample_two_s1, base_two_q);

	always_comb begin
		toggle    = 1'b0;
		upd_one   = 1'b0;
		upd_two   = 1'b0;
		dir_nxt   = dir_q;
		event_nxt = EV_NONE;
		priority if (ch1_strong && ch2_active) begin
			// Both channels firing: toggle the gripper once the lockout has elapsed, keep direction and baselines
			if (elapsed >= {16'h0000, lockout_q}) begin
				toggle    = 1'b1;
				event_nxt = grip_open_q ? EV_CLOSE : EV_OPEN;
			end
		end else if (ch1_strong) begin
			dir_nxt = DIR_POS;
			upd_two = 1'b1;
		end else if (ch2_neg) begin
			dir_nxt = DIR_NEG;
			upd_one = 1'b1;
		end else begin
			dir_nxt = DIR_IDLE;
			upd_one = 1'b1;
			upd_two = 1'b1;
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deviation_q <= DEVIATION_RST;
			lockout_q   <= LOCKOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DEVIATION: deviation_q <= cfg_data[DEV_W-1:0];
				CFG_LOCKOUT:   lockout_q   <= cfg_data[LOCK_W-1:0];
				CFG_BASE1,
				CFG_BASE2:     ;
				default:       ;
			endcase
		end
	end

	// Baselines: a start-value write loads them at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_one_q <= BASE_RST;
			base_two_q <= BASE_RST;
		end else begin
			priority if (cfg_we && cfg_index == CFG_BASE1) begin
				base_one_q <= cfg_data[SAMPLE_W-1:0];
			end else if (advance && upd_one) begin
				base_one_q <= blend_one;
			end else begin
				base_one_q <= base_one_q;
			end
			priority if (cfg_we && cfg_index == CFG_BASE2) begin
				base_two_q <= cfg_data[SAMPLE_W-1:0];
			end else if (advance && upd_two) begin
				base_two_q <= blend_two;
			end else begin
				base_two_q <= base_two_q;
			end
		end
	end

	// Direction, gripper and lockout state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q         <= DIR_IDLE;
			grip_open_q   <= 1'b0;
			last_toggle_q <= '0;
		end else if (advance) begin
			dir_q <= dir_nxt;
			if (toggle) begin
				grip_open_q   <= !grip_open_q;
				last_toggle_q <= now_ms_s1;
			end
		end
	end

	// Stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			sample_one_s1 <= samples.sample_one;
			sample_two_s1 <= samples.sample_two;
			now_ms_s1     <= samples.now_ms;
		end
	end

	// Stage 2: hold while stalled, drop once transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (results.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			direction_s2  <= dir_nxt;
			grip_event_s2 <= event_nxt;
		end
	end

	assign results.valid      = valid_s2;
	assign results.direction  = direction_s2;
	assign results.grip_event = grip_event_s2;

`ifndef SYNTH
	a_open_sets_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && event_nxt == EV_OPEN) |=> grip_open_q)
		else $error("gripper not open after open event");

	a_close_clears_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && event_nxt == EV_CLOSE) |=> !grip_open_q)
		else $error("gripper not closed after close event");

	a_toggle_keeps_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ch1_strong && ch2_active) |=> $stable(dir_q))
		else $error("direction moved on a gripper gesture");

	a_hold_state: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(grip_open_q) && $stable(last_toggle_q) && $stable(dir_q))
		else $error("state changed without an item advancing");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && !results.ready) |-> !samples.ready)
		else $error("input taken while both stages stalled");
`endif

endmodule

@@ test/emg_gesture_checker.sv @@
module emg_gesture_checker import emg_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	emg_sample_if                samples,
	emg_result_if                results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	output int                   pending,
	output int                   errors,
	output int                   results_seen,
	output int                   grip_toggles
);

	typedef struct packed {
		logic [DIR_W-1:0]   direction;
		logic [EVENT_W-1:0] grip_event;
	} gesture_t;

	// Local copy of the thresholds and of the classifier state
	logic [DEV_W-1:0]    margin;
	logic [LOCK_W-1:0]   lockout;
	logic [SAMPLE_W-1:0] floor_one;
	logic [SAMPLE_W-1:0] floor_two;
	logic [DIR_W-1:0]    joint_dir;
	logic                gripper_open;
	logic [TIME_W-1:0]   toggled_at;

	gesture_t awaited_gestures[$];
	int       fault_tally;
	int       seen_tally;
	int       toggle_tally;

	// Move a baseline two fifths of the way towards the sample, rounding down
	function automatic logic [SAMPLE_W-1:0] settle(input logic [SAMPLE_W-1:0] level,
			input logic [SAMPLE_W-1:0] base);
		int unsigned acc;
		acc = 2 * int'(level) + 3 * int'(base);
		return SAMPLE_W'(acc / 5);
	endfunction

	function automatic gesture_t classify(input logic [SAMPLE_W-1:0] s1,
			input logic [SAMPLE_W-1:0] s2, input logic [TIME_W-1:0] now);
		gesture_t          g;
		logic              strong_one;
		logic              active_two;
		logic [TIME_W-1:0] elapsed;
		strong_one   = int'(s1) > int'(floor_one) + 2 * int'(margin);
		active_two   = int'(s2) > int'(floor_two) + int'(margin);
		g.grip_event = EV_NONE;
		if (strong_one && active_two) begin
			elapsed = now - toggled_at;
			if (elapsed >= TIME_W'(lockout)) begin
				g.grip_event = gripper_open ? EV_CLOSE : EV_OPEN;
				gripper_open = !gripper_open;
				toggled_at   = now;
			end
		end else if (strong_one) begin
			joint_dir = DIR_POS;
			floor_two = settle(s2, floor_two);
		end else if (2 * int'(s2) > 2 * int'(floor_two) + int'(margin)) begin
			joint_dir = DIR_NEG;
			floor_one = settle(s1, floor_one);
		end else begin
			joint_dir = DIR_IDLE;
			floor_one = settle(s1, floor_one);
			floor_two = settle(s2, floor_two);
		end
		g.direction = joint_dir;
		return g;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		gesture_t want;
		if (!arst_n) begin
			margin       = DEVIATION_RST;
			lockout      = LOCKOUT_RST;
			floor_one    = BASE_RST;
			floor_two    = BASE_RST;
			joint_dir    = DIR_IDLE;
			gripper_open = 1'b0;
			toggled_at   = '0;
			awaited_gestures.delete();
			fault_tally  = 0;
			seen_tally   = 0;
			toggle_tally = 0;
		end else begin
			if (results.valid && results.ready) begin
				seen_tally++;
				if (awaited_gestures.size() == 0) begin
					if (fault_tally < 10)
						$display("Unexpected result at %0t: direction %0d grip_event %0d",
							$time, results.direction, results.grip_event);
					fault_tally++;
				end else begin
					want = awaited_gestures.pop_front();
					if (results.direction !== want.direction ||
							results.grip_event !== want.grip_event) begin
						if (fault_tally < 10)
							$display("Mismatch at %0t: direction exp %0d got %0d, %s %0d got %0d",
								$time, want.direction, results.direction,
								"grip_event exp", want.grip_event, results.grip_event);
						fault_tally++;
					end
				end
			end
			if (samples.valid && samples.ready) begin
				want = classify(samples.sample_one, samples.sample_two, samples.now_ms);
				if (want.grip_event != EV_NONE)
					toggle_tally++;
				awaited_gestures.push_back(want);
			end
			// a baseline write also reloads the running baseline
			if (cfg_we) begin
				case (cfg_index)
					CFG_DEVIATION: margin = cfg_data[DEV_W-1:0];
					CFG_LOCKOUT:   lockout = cfg_data[LOCK_W-1:0];
					CFG_BASE1: begin
						floor_one = cfg_data[SAMPLE_W-1:0];
					end
					CFG_BASE2: begin
						floor_two = cfg_data[SAMPLE_W-1:0];
					end
					default: ;
				endcase
			end
		end
		pending      <= awaited_gestures.size();
		errors       <= fault_tally;
		results_seen <= seen_tally;
		grip_toggles <= toggle_tally;
	end

endmodule

@@ test/emg_gesture_classifier_tb.sv @@
module emg_gesture_classifier_tb import emg_pkg::*;;

	localparam int CYCLE_LIMIT = 300000;
	localparam int HOLD_CYCLES = 300;
	localparam int PHASE_ITEMS = 300;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	emg_sample_if samples();
	emg_result_if results();

	int pending_results;
	int error_count;
	int results_seen;
	int grip_toggles;

	// Flow-control knobs: percentage of idle sender cycles and stalled receiver cycles
	int       src_idle_pct;
	int       stall_pct;
	// Each change of this request starts one long receiver hold-off
	logic [7:0] hold_req;

	// What the stimulus believes the thresholds and baselines to be
	logic [DEV_W-1:0]    nom_dev;
	logic [LOCK_W-1:0]   nom_lock;
	logic [SAMPLE_W-1:0] nom_one;
	logic [SAMPLE_W-1:0] nom_two;
	logic [TIME_W-1:0]   clock_ms;

	int items_sent;
	int settings_used;
	int cycle_count;

	emg_gesture_classifier DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (samples),
		.results   (results),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	emg_gesture_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.samples      (samples),
		.results      (results),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pending      (pending_results),
		.errors       (error_count),
		.results_seen (results_seen),
		.grip_toggles (grip_toggles)
	);

	always #10 clk = ~clk;

	// Guard against a hung handshake: count cycles and give up at the limit
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Run stopped after %0d cycles with %0d results outstanding",
			cycle_count, pending_results);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side: stall at random, or hold off for a long stretch on request
	initial begin
		int         hold_left;
		logic [7:0] hold_seen;
		hold_left     = 0;
		hold_seen     = '0;
		results.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				results.ready <= 1'b0;
			end else begin
				results.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one sample pair after a random idle gap, and hold it until the transfer
	task automatic offer(input logic [SAMPLE_W-1:0] s1, input logic [SAMPLE_W-1:0] s2,
			input logic [TIME_W-1:0] now);
		while ($urandom_range(99) < src_idle_pct) begin
			samples.valid <= 1'b0;
			@(posedge clk);
		end
		samples.valid      <= 1'b1;
		samples.sample_one <= s1;
		samples.sample_two <= s2;
		samples.now_ms     <= now;
		do @(posedge clk); while (!samples.ready);
		items_sent++;
	endtask

	// Stop offering until every predicted result has come back, then let the
	// pipeline settle; the outstanding count is registered, so it trails the queue
	task automatic drain();
		samples.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write all four registers; junk goes into the bits above the deviation and baseline widths
	task automatic configure(input logic [DEV_W-1:0] dev, input logic [LOCK_W-1:0] lock,
			input logic [SAMPLE_W-1:0] b1, input logic [SAMPLE_W-1:0] b2);
		logic [3:0] junk;
		junk      = 4'($urandom);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_DEVIATION;
		cfg_data  <= {junk, dev};
		@(posedge clk);
		cfg_index <= CFG_LOCKOUT;
		cfg_data  <= lock;
		@(posedge clk);
		cfg_index <= CFG_BASE1;
		cfg_data  <= {junk[0], b1};
		@(posedge clk);
		cfg_index <= CFG_BASE2;
		cfg_data  <= {junk[1], b2};
		@(posedge clk);
		cfg_we    <= 1'b0;
		nom_dev  = dev;
		nom_lock = lock;
		nom_one  = b1;
		nom_two  = b2;
		settings_used++;
	endtask

	// Build one item around the expected baselines: mostly a well-formed gesture
	// (rest, flex one, flex two, or both for a grip), with some pure noise
	task automatic gesture_item();
		int          pick;
		int          d;
		int          s1;
		int          s2;
		int          lock_i;
		logic [31:0] now;
		d      = int'(nom_dev);
		lock_i = int'(nom_lock);
		pick   = $urandom_range(99);
		clock_ms = clock_ms + $urandom_range(0, lock_i + lock_i / 2 + 1);
		now    = clock_ms;
		if (pick < 10) begin
			s1  = $urandom_range(32767);
			s2  = $urandom_range(32767);
			now = $urandom;
		end else begin
			case (pick % 4)
				0: begin
					s1 = int'(nom_one) + int'($urandom_range(0, 2 * d)) - d;
					s2 = int'(nom_two) - int'($urandom_range(0, d));
				end
				1: begin
					s1 = int'(nom_one) + 2 * d + int'($urandom_range(0, d + 300));
					s2 = int'(nom_two) - int'($urandom_range(0, d + 50));
				end
				2: begin
					s1 = int'(nom_one) - int'($urandom_range(0, d + 50));
					s2 = int'(nom_two) + d / 2 + int'($urandom_range(0, d + 300));
				end
				default: begin
					s1 = int'(nom_one) + 2 * d + 1 + int'($urandom_range(0, 300));
					s2 = int'(nom_two) + d + 1 + int'($urandom_range(0, 300));
				end
			endcase
		end
		if (s1 < 0) s1 = 0;
		if (s1 > 32767) s1 = 32767;
		if (s2 < 0) s2 = 0;
		if (s2 > 32767) s2 = 32767;
		offer(s1[SAMPLE_W-1:0], s2[SAMPLE_W-1:0], now);
	endtask

	initial begin
		int mode;
		clk                = 1'b0;
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = CFG_DEVIATION;
		cfg_data           = '0;
		samples.valid      = 1'b0;
		samples.sample_one = '0;
		samples.sample_two = '0;
		samples.now_ms     = '0;
		src_idle_pct       = 0;
		stall_pct          = 0;
		hold_req           = '0;
		nom_dev            = DEVIATION_RST;
		nom_lock           = LOCKOUT_RST;
		nom_one            = BASE_RST;
		nom_two            = BASE_RST;
		clock_ms           = '0;
		items_sent         = 0;
		settings_used      = 1;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset thresholds: rest, grip inside and outside the lockout, both
		// single-channel gestures, and a lockout spanning the timestamp wrap
		offer(15'd0, 15'd0, 32'd0);
		offer(15'h7FFF, 15'h7FFF, 32'd0);
		offer(15'h7FFF, 15'h7FFF, 32'd2000);
		offer(15'h7FFF, 15'h7FFF, 32'd3999);
		offer(15'h7FFF, 15'h7FFF, 32'd4000);
		offer(15'h7FFF, 15'd0, 32'd4100);
		offer(15'd0, 15'h7FFF, 32'd4200);
		offer(15'd1030, 15'd1030, 32'd4300);
		offer(15'h7FFF, 15'h7FFF, 32'hFFFF_FFFF);
		offer(15'h7FFF, 15'h7FFF, 32'h0000_07CE);
		offer(15'h7FFF, 15'h7FFF, 32'h0000_07CF);
		drain();

		// Largest thresholds: idle until the zero pair lowers the baselines; the last pair then reads as positive
		configure(12'hFFF, 16'hFFFF, 15'h7FFF, 15'h7FFF);
		offer(15'h7FFF, 15'h7FFF, 32'h8000_0000);
		offer(15'd0, 15'd0, 32'h8000_0001);
		offer(15'h7FFF, 15'd0, 32'hFFFF_FFFF);
		drain();

		// Zero margin and zero lockout: every grip toggles, even at the same time
		configure(12'd0, 16'd0, 15'd0, 15'd0);
		offer(15'd1, 15'd1, 32'd77);
		offer(15'd1, 15'd1, 32'd77);
		offer(15'd1, 15'd0, 32'd78);
		offer(15'd0, 15'd1, 32'd79);
		offer(15'd0, 15'd0, 32'd80);
		offer(15'h7FFF, 15'h7FFF, 32'd80);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 0;
					stall_pct   <= 0;
					configure(12'($urandom_range(0, 150)), 16'($urandom_range(0, 3000)),
						15'($urandom_range(300, 30000)), 15'($urandom_range(300, 30000)));
				end
				1: begin
					src_idle_pct = 81;
					stall_pct   <= 0;
					configure(12'($urandom_range(0, 150)), 16'hFFFF,
						15'($urandom_range(300, 30000)), 15'($urandom_range(300, 30000)));
				end
				2: begin
					src_idle_pct = 0;
					stall_pct   <= 81;
					configure(12'($urandom_range(3000, 4095)), 16'($urandom_range(0, 3000)),
						15'($urandom_range(0, 3000)), 15'($urandom_range(0, 3000)));
				end
				3: begin
					// run the timestamp through its wrap during this phase
					src_idle_pct = 22;
					stall_pct   <= 22;
					clock_ms     = 32'hFFFF_0000;
					configure(12'($urandom_range(0, 150)), 16'($urandom_range(0, 3000)),
						15'($urandom_range(300, 30000)), 15'($urandom_range(300, 30000)));
				end
				4: begin
					src_idle_pct = 0;
					stall_pct   <= 0;
					configure(12'd0, 16'd0, 15'd0, 15'd0);
				end
				default: begin
					configure(12'($urandom_range(0, 150)), 16'($urandom_range(0, 3000)),
						15'($urandom_range(300, 30000)), 15'($urandom_range(300, 30000)));
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// last phase: switch the flow-control mix every fifty items
				if (ph == 5 && n % 50 == 0) begin
					mode = $urandom_range(3);
					src_idle_pct = (mode == 1) ? 81 : (mode == 3) ? 22 : 0;
					stall_pct   <= (mode == 2) ? 81 : (mode == 3) ? 22 : 0;
				end
				// long hold-off on the result side while items keep coming,
				// so the pipeline fills and back-pressures the sample side
				if (ph == 0 && n == 100)
					hold_req <= hold_req + 8'd1;
				// mid-phase pause until everything outstanding has returned
				if (ph == 0 && n == 200)
					drain();
				gesture_item();
			end
			drain();
		end

		$display("Covered %0d sample transfers over %0d register settings, %s",
			items_sent, settings_used, "four flow-control mixes and a long result hold-off.");
		$display("Checked %0d results including %0d gripper toggles in %0d cycles.",
			results_seen, grip_toggles, cycle_count);
		if (error_count == 0 && pending_results == 0) begin
			$display("Testbench completed without errors");
		end else begin
			if (pending_results != 0)
				$display("%0d expected results never arrived", pending_results);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
sv/emg_pkg.sv
sv/emg_if.sv
sv/emg_gesture_classifier.sv
test/emg_gesture_checker.sv
test/emg_gesture_classifier_tb.sv
